### rtl/vfsc_pkg.sv
// Shared constants, types and codes for the video frame start code splitter.
package vfsc_pkg;

    // Default size of the downstream frame buffer in bytes
    localparam int BUFFER_BYTES_DEF = 65536;

    // Bytes between a stream position entering and being judged
    localparam int JUDGE_DELAY = 10;
    localparam int FILL_W      = $clog2(JUDGE_DELAY + 1);

    // Bytes of the window that the start code compares look at
    localparam int JUDGE_BYTES = 9;

    // Start code suffixes and masks
    localparam logic [7:0] SC_PREFIX_ONE = 8'h01;
    localparam logic [7:0] SC_SEQ        = 8'hB0;
    localparam logic [7:0] SC_VO         = 8'hB5;
    localparam logic [7:0] SC_VOP        = 8'hB6;
    localparam logic [7:0] H263_MASK     = 8'hF0;

    // Width of the boundary kind field
    localparam int KIND_W = 2;

    typedef logic [7:0] byte_t;

    // Judged window, element 0 is the position under judgment
    typedef byte_t [JUDGE_BYTES-1:0] judge_win_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEQ  = 2'd0,
        KIND_VOP  = 2'd1,
        KIND_H263 = 2'd2
    } kind_t;

    // Verdict of the detector for one stream position
    typedef struct packed {
        logic  hit;
        kind_t kind;
        logic  hdr_set;
        logic  hdr_clr;
    } verdict_t;

endpackage

### rtl/vfsc_judge.sv
// Start code detector: judges one stream position from the lookahead bytes.
module vfsc_judge
(
    input  vfsc_pkg::judge_win_t win,
    input  logic                 header_pending,
    output vfsc_pkg::verdict_t   verdict
);

    logic zero_pair;
    logic seq_hdr;
    logic vop_sc;
    logic h263_sc;

    // Match the start code patterns
    assign zero_pair = (win[0] == 8'h00) && (win[1] == 8'h00);
    assign seq_hdr   = zero_pair && (win[2] == vfsc_pkg::SC_PREFIX_ONE)
                       && (win[3] == vfsc_pkg::SC_SEQ)
                       && (win[5] == 8'h00) && (win[6] == 8'h00)
                       && (win[7] == vfsc_pkg::SC_PREFIX_ONE)
                       && (win[8] == vfsc_pkg::SC_VO);
    assign vop_sc    = zero_pair && (win[2] == vfsc_pkg::SC_PREFIX_ONE)
                       && (win[3] == vfsc_pkg::SC_VOP);
    assign h263_sc   = zero_pair && ((win[2] & vfsc_pkg::H263_MASK) != 8'h00);

    // Pick the verdict by priority
    always_comb
    begin
        verdict.hit     = 1'b0;
        verdict.kind    = vfsc_pkg::KIND_SEQ;
        verdict.hdr_set = 1'b0;
        verdict.hdr_clr = 1'b0;
        if (seq_hdr)
        begin
            verdict.hit     = 1'b1;
            verdict.kind    = vfsc_pkg::KIND_SEQ;
            verdict.hdr_set = 1'b1;
        end
        else if (vop_sc && header_pending)
        begin
            // first picture after a header only clears the flag
            verdict.hdr_clr = 1'b1;
        end
        else if (vop_sc)
        begin
            verdict.hit  = 1'b1;
            verdict.kind = vfsc_pkg::KIND_VOP;
        end
        else if (h263_sc)
        begin
            verdict.hit  = 1'b1;
            verdict.kind = vfsc_pkg::KIND_H263;
        end
    end

endmodule

### rtl/video_frame_start_code_splitter_core.sv
// Top level of the video frame start code splitter.
//
//  channel  | direction | tdata                   | tuser
//  ---------+-----------+-------------------------+------------------------
//  s_axis   | in        | data_byte [7:0]         | -
//  m_axis   | out       | frame_length [LEN_W-1:0]| boundary_kind [1:0]
//
// One byte beat is accepted per cycle while ready; the detector is a single
// combinational pass from the window registers into the output register, so
// a result shows in the cycle after the byte that completes it. A position is
// judged when the byte ten places later arrives. Reset clears the fill count,
// skip flag, length count and output valid, and sets the header flag. The input is
// ready whenever the output register is empty or being drained in the same cycle.
module video_frame_start_code_splitter_core
#(
    parameter int BUFFER_BYTES = vfsc_pkg::BUFFER_BYTES_DEF,
    parameter int LEN_W        = $clog2(BUFFER_BYTES + 1),
    parameter int TDATA_W      = ((LEN_W + 7) / 8) * 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [TDATA_W-1:0]          m_axis_tdata,   // [LEN_W-1:0] frame_length
    output logic [vfsc_pkg::KIND_W-1:0] m_axis_tuser    // [1:0] boundary_kind
);

    localparam int WIN_N = vfsc_pkg::JUDGE_DELAY;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUFFER_BYTES);
    localparam logic [vfsc_pkg::FILL_W-1:0] FILL_FULL =
        vfsc_pkg::FILL_W'(vfsc_pkg::JUDGE_DELAY);

    // Window registers: element 0 is the next position to judge
    vfsc_pkg::byte_t               win_reg [WIN_N];
    logic [vfsc_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic                          skip_reg, skip_next;
    logic                          hdr_reg, hdr_next;
    logic [LEN_W-1:0]              count_reg, count_next;

    logic                          out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]              out_len_reg, out_len_next;
    vfsc_pkg::kind_t               out_kind_reg, out_kind_next;

    logic                          in_fire;
    logic                          out_fire;
    vfsc_pkg::judge_win_t          judge_win;
    vfsc_pkg::verdict_t            verdict;
    logic [LEN_W-1:0]              count_adv;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Gather the judged bytes from the window
    always_comb
    begin
        for (int i = 0; i < vfsc_pkg::JUDGE_BYTES; i++)
        begin
            judge_win[i] = win_reg[i];
        end
    end

    vfsc_judge u_judge
    (
        .win            (judge_win),
        .header_pending (hdr_reg),
        .verdict        (verdict)
    );

    // Saturating advance of the length count
    assign count_adv = (count_reg == LEN_MAX) ? count_reg : count_reg + LEN_W'(1);

    // Next state for control, count and output register
    always_comb
    begin
        fill_next      = fill_reg;
        skip_next      = skip_reg;
        hdr_next       = hdr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_fire;
        out_len_next   = out_len_reg;
        out_kind_next  = out_kind_reg;
        if (in_fire)
        begin
            if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + vfsc_pkg::FILL_W'(1);
            end
            else if (skip_reg)
            begin
                skip_next  = 1'b0;
                count_next = count_adv;
            end
            else if (verdict.hit)
            begin
                if (verdict.hdr_set)
                begin
                    hdr_next = 1'b1;
                end
                count_next = LEN_W'(1);
                skip_next  = 1'b1;
                // drop zero-length frames
                if (count_reg != '0)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = count_reg;
                    out_kind_next  = verdict.kind;
                end
            end
            else
            begin
                if (verdict.hdr_clr)
                begin
                    hdr_next = 1'b0;
                end
                count_next = count_adv;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            skip_reg      <= 1'b0;
            hdr_reg       <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            hdr_reg       <= hdr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: shift the window and hold the result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < WIN_N - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_N-1] <= s_axis_tdata;
        end
        out_len_reg  <= out_len_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_len_reg);
    assign m_axis_tuser  = out_kind_reg;

endmodule
